### sv/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
package cfr_pkg;

	localparam int unsigned MAX_LEN_DEF   = 2048;
	localparam int unsigned TIMEOUT_RST   = 5000;
	localparam int unsigned TICK_W        = 20;
	localparam int unsigned COUNT_W       = 12;
	localparam int unsigned APB_AW        = 3;
	localparam int unsigned APB_DW        = 32;
	localparam logic [7:0]  HEADER_BYTE   = 8'h86;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// register word index (paddr[2])
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_CANCEL = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TIMEOUT   = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_READ_ERR  = 3'd4,
		ST_BAD_REQ   = 3'd5
	} status_e_t;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_HUNT    = 6'b000010,
		PH_LEN_HI  = 6'b000100,
		PH_LEN_LO  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_SKIP    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  rx_byte;
		logic [7:0]  expected_cmd;
		logic [15:0] expected_length;
	} item_t;

	typedef struct packed {
		logic               valid;
		logic               is_status;
		logic [7:0]         data_byte;
		logic               last;
		logic [2:0]         status;
		logic [COUNT_W-1:0] byte_count;
	} result_t;

endpackage

### sv/cfr_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface cfr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  rx_byte;
	logic [7:0]  expected_cmd;
	logic [15:0] expected_length;

	modport source (output valid, cmd, rx_byte, expected_cmd, expected_length, input ready);
	modport sink   (input valid, cmd, rx_byte, expected_cmd, expected_length, output ready);
endinterface

interface cfr_result_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [7:0]  data_byte;
	logic        last;
	logic [2:0]  status;
	logic [11:0] byte_count;

	modport source (output valid, is_status, data_byte, last, status, byte_count, input ready);
	modport sink   (input valid, is_status, data_byte, last, status, byte_count, output ready);
endinterface

### sv/cfr_core.sv
// Receive state machine: one item per fire, result computed combinationally.
module cfr_core #(
	parameter int unsigned MAX_LEN = cfr_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  cfr_pkg::item_t              item,
	input  logic [cfr_pkg::TICK_W-1:0]  timeout_ticks,
	output cfr_pkg::result_t            res
);
	import cfr_pkg::*;

	localparam int unsigned PCW  = $clog2(MAX_LEN + 1);
	localparam int unsigned SUMW = (PCW + 1 > COUNT_W) ? PCW + 1 : COUNT_W;

	phase_t            phase_q,   phase_n;
	logic [7:0]        want_cmd_q, want_cmd_n;
	logic [15:0]       want_len_q, want_len_n;
	logic [7:0]        len_hi_q,  len_hi_n;
	logic [PCW-1:0]    pcount_q,  pcount_n;
	logic [TICK_W-1:0] elapsed_q, elapsed_n;

	logic [PCW-1:0]    pcount_inc;
	logic [SUMW-1:0]   fsum, fsum_inc;
	logic [COUNT_W-1:0] fcount;
	logic [15:0]       len_rx;
	logic [TICK_W-1:0] elapsed_inc;
	logic              mid;

	assign pcount_inc  = pcount_q + PCW'(1);
	assign fsum        = SUMW'(pcount_q) + SUMW'(3);
	assign fsum_inc    = SUMW'(pcount_inc) + SUMW'(3);
	assign len_rx      = {len_hi_q, item.rx_byte};
	assign elapsed_inc = (elapsed_q != TICK_MAX) ? elapsed_q + TICK_W'(1) : elapsed_q;
	assign mid = (phase_q == PH_LEN_LO) ||
		(((phase_q == PH_PAYLOAD) || (phase_q == PH_SKIP)) && (pcount_q != '0));

	always_comb begin
		case (phase_q)
			PH_LEN_HI:  fcount = COUNT_W'(1);
			PH_LEN_LO:  fcount = COUNT_W'(2);
			PH_PAYLOAD,
			PH_SKIP:    fcount = fsum[COUNT_W-1:0];
			default:    fcount = '0;
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		want_cmd_n = want_cmd_q;
		want_len_n = want_len_q;
		len_hi_n   = len_hi_q;
		pcount_n   = pcount_q;
		elapsed_n  = elapsed_q;
		res        = '0;
		res.status = ST_OK;

		if (item.cmd == CMD_START) begin
			if (item.expected_length == '0) begin
				phase_n       = PH_IDLE;
				res.valid     = 1'b1;
				res.is_status = 1'b1;
				res.status    = ST_BAD_REQ;
			end else begin
				want_cmd_n = item.expected_cmd;
				want_len_n = item.expected_length;
				len_hi_n   = '0;
				pcount_n   = '0;
				elapsed_n  = '0;
				phase_n    = PH_HUNT;
			end
		end else if (phase_q != PH_IDLE) begin
			case (item.cmd)
				CMD_CANCEL: begin
					res.valid      = 1'b1;
					res.is_status  = 1'b1;
					res.status     = ST_CANCELLED;
					res.byte_count = fcount;
					phase_n        = PH_IDLE;
				end
				CMD_TICK: begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= timeout_ticks) begin
						res.valid      = 1'b1;
						res.is_status  = 1'b1;
						res.status     = mid ? ST_READ_ERR : ST_TIMEOUT;
						res.byte_count = fcount;
						phase_n        = PH_IDLE;
					end
				end
				CMD_BYTE: begin
					case (phase_q)
						PH_HUNT: begin
							if (item.rx_byte == HEADER_BYTE)
								phase_n = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							len_hi_n = item.rx_byte;
							phase_n  = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							len_hi_n = '0;
							if (len_rx != want_len_q) begin
								phase_n = PH_HUNT;
							end else if (len_rx > 16'(MAX_LEN)) begin
								res.valid      = 1'b1;
								res.is_status  = 1'b1;
								res.status     = ST_TOO_LARGE;
								res.byte_count = COUNT_W'(3);
								phase_n        = PH_IDLE;
							end else begin
								pcount_n = '0;
								phase_n  = PH_PAYLOAD;
							end
						end
						PH_PAYLOAD: begin
							pcount_n = pcount_inc;
							if ((pcount_q == '0) && (item.rx_byte != want_cmd_q)) begin
								phase_n = (want_len_q == 16'd1) ? PH_HUNT : PH_SKIP;
							end else begin
								res.valid      = 1'b1;
								res.data_byte  = item.rx_byte;
								res.byte_count = fsum_inc[COUNT_W-1:0];
								if (16'(pcount_inc) >= want_len_q) begin
									res.is_status = 1'b1;
									res.last      = 1'b1;
									phase_n       = PH_IDLE;
								end
							end
						end
						PH_SKIP: begin
							pcount_n = pcount_inc;
							if (16'(pcount_inc) >= want_len_q)
								phase_n = PH_HUNT;
						end
						default: phase_n = PH_IDLE;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			want_cmd_q <= '0;
			want_len_q <= '0;
			len_hi_q   <= '0;
			pcount_q   <= '0;
			elapsed_q  <= '0;
		end else if (fire) begin
			phase_q    <= phase_n;
			want_cmd_q <= want_cmd_n;
			want_len_q <= want_len_n;
			len_hi_q   <= len_hi_n;
			pcount_q   <= pcount_n;
			elapsed_q  <= elapsed_n;
		end
	end

endmodule

### sv/command_frame_receiver_top.sv
// Top level of the command frame receiver: channels, APB register, stage registers.
//
// Usage:
//  - items (valid/ready): one beat per start, received byte, tick or cancel.
//    A start arms the receiver with the expected command and payload length;
//    byte beats are scanned for header 0x86, a big-endian 16-bit length and
//    the payload; tick beats count toward the timeout; cancel aborts.
//  - results (valid/ready): at most one beat per item. Payload bytes come out
//    one per beat; the final one has is_status, last and status ok. Other
//    status beats (timeout, cancel, length too large, read error, bad
//    request) carry data_byte 0 and the frame byte count so far.
//  - APB: one register, timeout_ticks, at address 0. Write it only while idle.
// Timing: an accepted item is registered in the input stage, its result in the
// result stage. Throughput is one item per cycle while results.ready is high;
// the decision path is a handful of compares and one 20-bit counter between the
// input stage and result stage. When results.ready is low the result register
// holds, the input stage fills, and items.ready drops; nothing is lost. Reset
// clears both stages, puts the receiver in idle and restores timeout_ticks to 5000.
module command_frame_receiver_top #(
	parameter int unsigned MAX_LEN = cfr_pkg::MAX_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cfr_item_if.sink                    items,
	cfr_result_if.source                results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::APB_AW-1:0]  paddr,
	input  logic [cfr_pkg::APB_DW-1:0]  pwdata,
	output logic [cfr_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import cfr_pkg::*;

	logic [TICK_W-1:0] timeout_q;
	item_t             item_s1;
	logic              valid_s1;
	result_t           res_s2;
	result_t           core_res;
	logic              advance;
	logic              fire;
	logic              accept;

	// APB: word index is paddr[2]; byte lanes ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? APB_DW'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TICK_W'(TIMEOUT_RST);
		end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
			timeout_q <= pwdata[TICK_W-1:0];
		end
	end

	// Result stage moves when empty or being taken; input stage moves with it.
	assign advance     = !res_s2.valid || results.ready;
	assign fire        = valid_s1 && advance;
	assign items.ready = !valid_s1 || advance;
	assign accept      = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd             <= items.cmd;
			item_s1.rx_byte         <= items.rx_byte;
			item_s1.expected_cmd    <= items.expected_cmd;
			item_s1.expected_length <= items.expected_length;
		end
	end

	cfr_core #(
		.MAX_LEN (MAX_LEN)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.res           (core_res)
	);

	// valid bit moves with the stage; payload loads only on a new beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			if (advance) begin
				res_s2.valid <= fire && core_res.valid;
			end
			if (fire && core_res.valid) begin
				res_s2.is_status  <= core_res.is_status;
				res_s2.data_byte  <= core_res.data_byte;
				res_s2.last       <= core_res.last;
				res_s2.status     <= core_res.status;
				res_s2.byte_count <= core_res.byte_count;
			end
		end
	end

	assign results.valid      = res_s2.valid;
	assign results.is_status  = res_s2.is_status;
	assign results.data_byte  = res_s2.data_byte;
	assign results.last       = res_s2.last;
	assign results.status     = res_s2.status;
	assign results.byte_count = res_s2.byte_count;

endmodule

### sv/cfr_checker.sv
// Port-level checks for the command frame receiver, bound to the top level.
module cfr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic        is_status,
	input  logic        last,
	input  logic [2:0]  status,
	input  logic [11:0] byte_count
);
	import cfr_pkg::*;

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result beat dropped while stalled");

	// last byte always closes the receive with ok
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> is_status && (status == ST_OK))
		else $error("last beat without ok status");

	// plain data beats carry ok status, no last flag and a byte count of at least 4
	a_data_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_status |-> (status == ST_OK) && !last && (byte_count >= 12'd4))
		else $error("malformed payload beat");

	// ok status only on a last byte
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_status && (status == ST_OK) |-> last)
		else $error("ok status without last");

	// fixed counts on bad request and oversized length
	a_fixed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ((status == ST_BAD_REQ) || (status == ST_TOO_LARGE)) |->
		((status == ST_BAD_REQ) && (byte_count == 12'd0)) ||
		((status == ST_TOO_LARGE) && (byte_count == 12'd3)))
		else $error("unexpected count on error status");

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (results.valid),
	.ready      (results.ready),
	.is_status  (results.is_status),
	.last       (results.last),
	.status     (results.status),
	.byte_count (results.byte_count)
);

### verif/tb.sv
// Testbench for command_frame_receiver_top: random frame traffic checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import cfr_pkg::*;

	// one expected result beat
	typedef struct {
		logic        is_status;
		logic [7:0]  data_byte;
		logic        last;
		status_e_t   status;
		logic [11:0] byte_count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	cfr_item_if   items_ch ();
	cfr_result_if results_ch ();

	command_frame_receiver_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// beats waiting to go out on the item channel, and replies owed by the block
	item_t  rx_stream_q[$];
	reply_t replies_due[$];
	int     queued_total = 0;
	int     mismatches = 0;

	// traffic shaping; the percentages change between phases only
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_arm = 1'b0;
	logic rx_hold = 1'b0;

	// predictor state: mirrors the receiver's view of the stream
	phase_t      rcv_phase = PH_IDLE;
	logic [7:0]  arm_cmd = '0;
	logic [15:0] arm_len = '0;
	logic [7:0]  len_msb = '0;
	logic [11:0] pay_seen = '0;
	logic [TICK_W-1:0] ticks_used = '0;
	logic [TICK_W-1:0] tmo_ticks = TICK_W'(TIMEOUT_RST);

	// bytes of the frame taken so far, header and length included
	function automatic logic [11:0] frame_bytes();
		case (rcv_phase)
			PH_LEN_HI:          return 12'd1;
			PH_LEN_LO:          return 12'd2;
			PH_PAYLOAD, PH_SKIP: return 12'd3 + pay_seen;
			default:            return 12'd0;
		endcase
	endfunction

	// advance the receiver by one accepted item, queue the reply it owes, if any
	task automatic track_receiver(item_t it);
		reply_t      r;
		logic        emit;
		logic [15:0] len;
		logic        mid;
		emit = 1'b0;
		r.is_status = 1'b1;
		r.data_byte = 8'h00;
		r.last = 1'b0;
		r.status = ST_OK;
		r.byte_count = 12'd0;
		if (it.cmd == CMD_START) begin
			if (it.expected_length == 16'd0) begin
				rcv_phase = PH_IDLE;
				r.status = ST_BAD_REQ;
				emit = 1'b1;
			end else begin
				arm_cmd = it.expected_cmd;
				arm_len = it.expected_length;
				len_msb = '0;
				pay_seen = '0;
				ticks_used = '0;
				rcv_phase = PH_HUNT;
			end
		end else if (rcv_phase != PH_IDLE) begin
			case (it.cmd)
				CMD_CANCEL: begin
					r.status = ST_CANCELLED;
					r.byte_count = frame_bytes();
					emit = 1'b1;
					rcv_phase = PH_IDLE;
				end
				CMD_TICK: begin
					if (ticks_used != TICK_MAX)
						ticks_used = ticks_used + 1'b1;
					if (ticks_used >= tmo_ticks) begin
						// partway through a length word or a payload is a read error
						mid = (rcv_phase == PH_LEN_LO) ||
							((rcv_phase == PH_PAYLOAD || rcv_phase == PH_SKIP) && pay_seen != 0);
						r.status = mid ? ST_READ_ERR : ST_TIMEOUT;
						r.byte_count = frame_bytes();
						emit = 1'b1;
						rcv_phase = PH_IDLE;
					end
				end
				default: begin
					case (rcv_phase)
						PH_HUNT:
							if (it.rx_byte == HEADER_BYTE)
								rcv_phase = PH_LEN_HI;
						PH_LEN_HI: begin
							len_msb = it.rx_byte;
							rcv_phase = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							len = {len_msb, it.rx_byte};
							len_msb = '0;
							if (len != arm_len) begin
								rcv_phase = PH_HUNT;
							end else if (len > MAX_LEN_DEF) begin
								r.status = ST_TOO_LARGE;
								r.byte_count = 12'd3;
								emit = 1'b1;
								rcv_phase = PH_IDLE;
							end else begin
								pay_seen = '0;
								rcv_phase = PH_PAYLOAD;
							end
						end
						PH_PAYLOAD: begin
							pay_seen = pay_seen + 1'b1;
							if (pay_seen == 1 && it.rx_byte != arm_cmd) begin
								rcv_phase = (arm_len == 16'd1) ? PH_HUNT : PH_SKIP;
							end else begin
								r.data_byte = it.rx_byte;
								r.byte_count = 12'd3 + pay_seen;
								emit = 1'b1;
								if (pay_seen >= arm_len) begin
									r.last = 1'b1;
									rcv_phase = PH_IDLE;
								end else begin
									r.is_status = 1'b0;
								end
							end
						end
						PH_SKIP: begin
							pay_seen = pay_seen + 1'b1;
							if (pay_seen >= arm_len)
								rcv_phase = PH_HUNT;
						end
						default: rcv_phase = PH_IDLE;
					endcase
				end
			endcase
		end
		if (emit)
			replies_due.push_back(r);
	endtask

	// item driver: a beat is taken on valid && ready, prediction happens right there
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
		end else begin : drive
			item_t nxt;
			if (items_ch.valid && items_ch.ready)
				track_receiver({items_ch.cmd, items_ch.rx_byte,
					items_ch.expected_cmd, items_ch.expected_length});
			if (!items_ch.valid || items_ch.ready) begin
				if (rx_stream_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					nxt = rx_stream_q.pop_front();
					items_ch.valid <= 1'b1;
					items_ch.cmd <= nxt.cmd;
					items_ch.rx_byte <= nxt.rx_byte;
					items_ch.expected_cmd <= nxt.expected_cmd;
					items_ch.expected_length <= nxt.expected_length;
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result monitor: compares every accepted beat with the oldest owed reply
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else begin : watch
			reply_t exp_r;
			if (results_ch.valid && results_ch.ready) begin
				if (replies_due.size() == 0) begin
					$error("result beat with nothing expected: count %0d status %0d",
						results_ch.byte_count, results_ch.status);
					mismatches++;
				end else begin
					exp_r = replies_due.pop_front();
					check_field("is_status", exp_r.is_status, results_ch.is_status);
					check_field("data_byte", exp_r.data_byte, results_ch.data_byte);
					check_field("last", exp_r.last, results_ch.last);
					check_field("status", exp_r.status, results_ch.status);
					check_field("byte_count", exp_r.byte_count, results_ch.byte_count);
				end
			end
			results_ch.ready <= !rx_hold && ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// long back-pressure stretch, counted here once armed
	initial begin
		wait (hold_arm);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic add_beat(cmd_e_t k, logic [7:0] rx, logic [7:0] ec, logic [15:0] el);
		item_t it;
		it.cmd = k;
		it.rx_byte = rx;
		it.expected_cmd = ec;
		it.expected_length = el;
		rx_stream_q.push_back(it);
		queued_total++;
	endtask

	// unused fields carry random bits so every input bit toggles
	task automatic add_byte(logic [7:0] b);
		add_beat(CMD_BYTE, b, 8'($urandom), 16'($urandom));
	endtask

	task automatic maybe_tick(int pct);
		if ($urandom_range(99, 0) < pct)
			add_beat(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// one receive: start, some line noise, maybe a wrong-length frame, then the real frame
	task automatic add_session(int tick_pct);
		logic [7:0]  ec;
		logic [7:0]  flip;
		logic [15:0] el;
		logic [15:0] bogus;
		int          pick;
		int          cut;
		ec = 8'($urandom);
		pick = $urandom_range(99, 0);
		if (pick < 70)
			el = 16'($urandom_range(8, 1));
		else if (pick < 88)
			el = 16'($urandom_range(40, 9));
		else if (pick < 96)
			el = 16'($urandom_range(65535, MAX_LEN_DEF + 1));
		else
			el = 16'd0;
		add_beat(CMD_START, 8'($urandom), ec, el);
		if (el == 0)
			return;
		repeat ($urandom_range(3, 0)) begin
			add_byte(8'($urandom));
			maybe_tick(tick_pct);
		end
		if ($urandom_range(99, 0) < 20) begin
			bogus = el ^ (16'h0001 << $urandom_range(15, 0));
			add_byte(HEADER_BYTE);
			add_byte(bogus[15:8]);
			add_byte(bogus[7:0]);
		end
		add_byte(HEADER_BYTE);
		maybe_tick(tick_pct);
		add_byte(el[15:8]);
		maybe_tick(tick_pct);
		add_byte(el[7:0]);
		if (el > MAX_LEN_DEF)
			return;
		// cut short: below 10 a cancel follows, otherwise the next start re-arms
		pick = $urandom_range(99, 0);
		cut = (pick < 15) ? $urandom_range(el - 1, 0) : el;
		for (int i = 0; i < cut; i++) begin
			if (i == 0) begin
				flip = 8'($urandom_range(255, 1));
				add_byte(($urandom_range(99, 0) < 85) ? ec : ec ^ flip);
			end else begin
				add_byte(8'($urandom));
			end
			maybe_tick(tick_pct);
		end
		if (pick < 10)
			add_beat(CMD_CANCEL, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic add_noise(int n);
		repeat (n)
			add_beat(cmd_e_t'($urandom_range(3, 0)), 8'($urandom), 8'($urandom),
				16'($urandom));
	endtask

	// wait until every owed reply is in and the pipeline has emptied
	task automatic drain();
		while (rx_stream_q.size() != 0 || items_ch.valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_timeout(logic [TICK_W-1:0] v);
		logic [APB_DW-1:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TIMEOUT, 2'b00};
		pwdata <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		tmo_ticks = v;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[TICK_W-1:0] != v) begin
			$error("timeout_ticks: expected %0h, got %0h", v, rd[TICK_W-1:0]);
			mismatches++;
		end
	endtask

	// one phase of random traffic under one register setting and one idling profile
	task automatic run_phase(logic [TICK_W-1:0] tmo, int sidle, int rstall, int n, int tick_pct);
		int goal;
		drain();
		set_timeout(tmo);
		@(negedge clk);
		send_idle_pct <= sidle;
		recv_stall_pct <= rstall;
		goal = queued_total + n;
		while (queued_total < goal) begin
			if ($urandom_range(99, 0) < 85)
				add_session(tick_pct);
			else
				add_noise($urandom_range(6, 1));
		end
	endtask

	initial begin
		items_ch.valid = 1'b0;
		items_ch.cmd = CMD_START;
		items_ch.rx_byte = '0;
		items_ch.expected_cmd = '0;
		items_ch.expected_length = '0;
		results_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle items do nothing
		add_beat(CMD_BYTE, HEADER_BYTE, 8'hFF, 16'hFFFF);
		add_beat(CMD_TICK, 8'h00, 8'h00, 16'h0000);
		add_beat(CMD_CANCEL, 8'hFF, 8'hFF, 16'hFFFF);
		// zero length is a bad request
		add_beat(CMD_START, 8'hFF, 8'h3C, 16'h0000);
		// largest length matches but is too large
		add_beat(CMD_START, 8'h00, 8'hFF, 16'hFFFF);
		add_byte(HEADER_BYTE);
		add_byte(8'hFF);
		add_byte(8'hFF);
		// wrong length drops the frame, then a one-byte good frame
		add_beat(CMD_START, 8'hA5, 8'h00, 16'h0001);
		add_byte(HEADER_BYTE);
		add_byte(8'h00);
		add_byte(8'h02);
		add_byte(HEADER_BYTE);
		add_byte(8'h00);
		add_byte(8'h01);
		add_byte(8'h00);
		// re-arm while active, command mismatch skips the payload, cancel in a header
		add_beat(CMD_START, 8'h00, 8'h5A, 16'h0002);
		add_beat(CMD_START, 8'hFF, 8'hA5, 16'h0002);
		add_byte(HEADER_BYTE);
		add_byte(8'h00);
		add_byte(8'h02);
		add_byte(8'h11);
		add_byte(8'h22);
		add_byte(HEADER_BYTE);
		add_beat(CMD_CANCEL, 8'h00, 8'h00, 16'h0000);

		run_phase(20'd1, 0, 0, 250, 4);
		run_phase(20'd1000000, 83, 0, 250, 10);
		run_phase(20'd4, 0, 83, 250, 12);
		run_phase(20'd12, 28, 28, 250, 10);

		// pressure: a long frame plus traffic, result side held off for a while
		drain();
		set_timeout(TICK_W'(TIMEOUT_RST));
		@(negedge clk);
		send_idle_pct <= 0;
		recv_stall_pct <= 0;
		add_beat(CMD_START, 8'($urandom), 8'hC3, 16'd200);
		add_byte(HEADER_BYTE);
		add_byte(8'h00);
		add_byte(8'hC8);
		add_byte(8'hC3);
		repeat (199) add_byte(8'($urandom));
		hold_arm = 1'b1;
		while (queued_total < 1300) begin
			if ($urandom_range(99, 0) < 85)
				add_session(2);
			else
				add_noise($urandom_range(6, 1));
		end
		drain();

		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
